// ===== rtl/rlh_pkg.sv =====
`default_nettype none
package rlh_pkg;

   localparam int NumBuckets = 14;
   localparam int BucketWidth = 4;

   localparam logic [2:0] StatusStored    = 3'd0;
   localparam logic [2:0] StatusDuplicate = 3'd1;
   localparam logic [2:0] StatusFull      = 3'd2;
   localparam logic [2:0] StatusIssueNull = 3'd3;
   localparam logic [2:0] StatusCompleted = 3'd4;
   localparam logic [2:0] StatusMiss      = 3'd5;
   localparam logic [2:0] StatusCplNull   = 3'd6;

   localparam logic OpIssue    = 1'b0;
   localparam logic OpComplete = 1'b1;

   // exclusive upper bounds of buckets 0 to 12
   function automatic logic [BucketWidth-1:0] bucket_of(input logic [63:0] lat);
      logic [63:0] bound [0:12];
      logic [BucketWidth-1:0] idx;
      bound[0]  = 64'd100000;     bound[1]  = 64'd250000;    bound[2]  = 64'd500000;
      bound[3]  = 64'd1000000;    bound[4]  = 64'd2000000;   bound[5]  = 64'd5000000;
      bound[6]  = 64'd10000000;   bound[7]  = 64'd20000000;  bound[8]  = 64'd50000000;
      bound[9]  = 64'd100000000;  bound[10] = 64'd250000000; bound[11] = 64'd500000000;
      bound[12] = 64'd1000000000;
      idx = BucketWidth'(NumBuckets - 1);
      for (int b = 12; b >= 0; b--) begin
         if (lat < bound[b]) idx = BucketWidth'(b);
      end
      return idx;
   endfunction

   // controller commands to the datapath
   typedef struct packed {
      logic lookup;   // capture the word and search the table
      logic apply;    // act on the search result, update stats, load response
   } rlh_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/rlh_ctrl.sv =====
`default_nettype none
module rlh_ctrl
   import rlh_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output rlh_cmd_type cmd
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StSearch = 2'd1;
   localparam logic [1:0] StReply  = 2'd2;

   logic [1:0] state_ff, state_in;

   // a new word may enter as the reply is taken; while the reply waits, the request is stalled
   assign req_stall = (state_ff == StSearch) || (state_ff == StReply && rsp_stall);
   assign rsp_valid = (state_ff == StReply);
   assign cmd.lookup = req_valid && !req_stall;
   assign cmd.apply  = (state_ff == StSearch);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle:   if (cmd.lookup) state_in = StSearch;
         StSearch: state_in = StReply;
         StReply: begin
            if (!rsp_stall) state_in = cmd.lookup ? StSearch : StIdle;
         end
         default:  state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else       state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid) else $error("apply not followed by reply");
   assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> cmd.apply) else $error("lookup not followed by apply");
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.lookup && cmd.apply)) else $error("lookup during apply");

endmodule
`default_nettype wire

// ===== rtl/rlh_datapath.sv =====
`default_nettype none
module rlh_datapath
   import rlh_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rlh_cmd_type            cmd,
   input  wire logic                   req_op,
   input  wire logic                   req_request_null,
   input  wire logic [63:0]            req_request_key,
   input  wire logic [63:0]            req_timestamp_ns,
   output logic [2:0]                  rsp_status,
   output logic [63:0]                 rsp_event_counter,
   output logic [63:0]                 rsp_delay_ns,
   output logic [BucketWidth-1:0]      rsp_bucket_index,
   output logic [63:0]                 rsp_bucket_count,
   output logic [63:0]                 rsp_completed_count,
   output logic [63:0]                 rsp_total_delay_ns,
   output logic [63:0]                 rsp_min_delay_ns,
   output logic [63:0]                 rsp_max_delay_ns
);

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic                  valid_ff [TABLE_ENTRIES];
   logic [63:0]           key_ff   [TABLE_ENTRIES];
   logic [63:0]           time_ff  [TABLE_ENTRIES];

   logic                  op_ff, null_ff;
   logic [63:0]           rkey_ff, now_ff;
   logic                  hit_ff, free_ff;
   logic [IdxW-1:0]       hit_idx_ff, free_idx_ff;
   logic                  hit_in, free_in;
   logic [IdxW-1:0]       hit_idx_in, free_idx_in;

   logic [63:0] issue_cnt_ff, cpl_cnt_ff, null_cnt_ff, dup_cnt_ff, miss_cnt_ff, full_cnt_ff;
   logic [63:0] rec_ff, sum_ff, min_ff, max_ff;
   logic [63:0] hist_ff [NumBuckets];

   logic [63:0]           lat;
   logic [BucketWidth-1:0] bidx;
   logic [63:0]           bcnt;

   // parallel key compare and free slot pick
   always_comb begin
      hit_in = 1'b0; hit_idx_in = '0;
      free_in = 1'b0; free_idx_in = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_request_key) begin
            hit_in = 1'b1; hit_idx_in = IdxW'(i);
         end
         if (!valid_ff[i]) begin
            free_in = 1'b1; free_idx_in = IdxW'(i);
         end
      end
   end

   assign lat  = now_ff - time_ff[hit_idx_ff];
   assign bidx = bucket_of(lat);
   assign bcnt = hist_ff[bidx] + 64'd1;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         op_ff <= req_op; null_ff <= req_request_null;
         rkey_ff <= req_request_key; now_ff <= req_timestamp_ns;
         hit_ff <= hit_in; hit_idx_ff <= hit_idx_in;
         free_ff <= free_in; free_idx_ff <= free_idx_in;
      end
      if (cmd.apply) begin
         rsp_delay_ns <= '0; rsp_bucket_index <= '0; rsp_bucket_count <= '0;
         rsp_completed_count <= rec_ff; rsp_total_delay_ns <= sum_ff;
         rsp_min_delay_ns <= min_ff; rsp_max_delay_ns <= max_ff;
         if (op_ff == OpIssue) begin
            if (null_ff) begin
               rsp_status <= StatusIssueNull; rsp_event_counter <= null_cnt_ff + 64'd1;
            end else if (hit_ff) begin
               time_ff[hit_idx_ff] <= now_ff;
               rsp_status <= StatusDuplicate; rsp_event_counter <= dup_cnt_ff + 64'd1;
            end else if (free_ff) begin
               key_ff[free_idx_ff] <= rkey_ff; time_ff[free_idx_ff] <= now_ff;
               rsp_status <= StatusStored; rsp_event_counter <= issue_cnt_ff + 64'd1;
            end else begin
               rsp_status <= StatusFull; rsp_event_counter <= full_cnt_ff + 64'd1;
            end
         end else begin
            if (null_ff) begin
               rsp_status <= StatusCplNull; rsp_event_counter <= null_cnt_ff + 64'd1;
            end else if (!hit_ff) begin
               rsp_status <= StatusMiss; rsp_event_counter <= miss_cnt_ff + 64'd1;
            end else begin
               rsp_status <= StatusCompleted; rsp_event_counter <= rec_ff + 64'd1;
               rsp_delay_ns <= lat; rsp_bucket_index <= bidx; rsp_bucket_count <= bcnt;
               rsp_completed_count <= rec_ff + 64'd1; rsp_total_delay_ns <= sum_ff + lat;
               rsp_min_delay_ns <= (rec_ff == '0 || lat < min_ff) ? lat : min_ff;
               rsp_max_delay_ns <= (lat > max_ff) ? lat : max_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) valid_ff[i] <= 1'b0;
         for (int b = 0; b < NumBuckets; b++) hist_ff[b] <= '0;
         issue_cnt_ff <= '0; cpl_cnt_ff <= '0; null_cnt_ff <= '0; dup_cnt_ff <= '0;
         miss_cnt_ff <= '0; full_cnt_ff <= '0;
         rec_ff <= '0; sum_ff <= '0; min_ff <= '0; max_ff <= '0;
      end else if (cmd.apply) begin
         if (op_ff == OpIssue) issue_cnt_ff <= issue_cnt_ff + 64'd1;
         else                  cpl_cnt_ff <= cpl_cnt_ff + 64'd1;
         if (null_ff) null_cnt_ff <= null_cnt_ff + 64'd1;
         else if (op_ff == OpIssue) begin
            if (hit_ff) dup_cnt_ff <= dup_cnt_ff + 64'd1;
            else if (free_ff) valid_ff[free_idx_ff] <= 1'b1;
            else full_cnt_ff <= full_cnt_ff + 64'd1;
         end else if (!hit_ff) miss_cnt_ff <= miss_cnt_ff + 64'd1;
         else begin
            valid_ff[hit_idx_ff] <= 1'b0;
            hist_ff[bidx] <= bcnt;
            rec_ff <= rec_ff + 64'd1;
            sum_ff <= sum_ff + lat;
            if (rec_ff == '0 || lat < min_ff) min_ff <= lat;
            if (lat > max_ff) max_ff <= lat;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.apply && !null_ff && hit_ff |-> valid_ff[hit_idx_ff])
      else $error("hit on invalid slot");
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply && !null_ff && op_ff == OpIssue && !hit_ff && free_ff
      |-> !valid_ff[free_idx_ff]) else $error("free slot already taken");
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.apply) && rec_ff != '0 |-> min_ff <= max_ff)
      else $error("min above max");

endmodule
`default_nettype wire

// ===== rtl/request_latency_histogram.sv =====
// a word is accepted, searched and applied, then its result waits in the reply state until taken
// a new word is taken only once the last reply is taken; search and update share the slot table
// the table search is registered, then the apply step writes the table and statistics
// reset (synchronous, active high) empties the table and clears every counter,
// the histogram and min/max at once; no clearing pass
`default_nettype none
module request_latency_histogram
   import rlh_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic        req_request_null,
   input  wire logic [63:0] req_request_key,
   input  wire logic [63:0] req_timestamp_ns,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_event_counter,
   output logic [63:0]      rsp_delay_ns,
   output logic [3:0]       rsp_bucket_index,
   output logic [63:0]      rsp_bucket_count,
   output logic [63:0]      rsp_completed_count,
   output logic [63:0]      rsp_total_delay_ns,
   output logic [63:0]      rsp_min_delay_ns,
   output logic [63:0]      rsp_max_delay_ns
);

   rlh_cmd_type cmd;

   rlh_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd
   );

   rlh_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
      .clock, .reset, .cmd,
      .req_op, .req_request_null, .req_request_key, .req_timestamp_ns,
      .rsp_status, .rsp_event_counter, .rsp_delay_ns, .rsp_bucket_index,
      .rsp_bucket_count, .rsp_completed_count, .rsp_total_delay_ns,
      .rsp_min_delay_ns, .rsp_max_delay_ns
   );

endmodule
`default_nettype wire
